FILE: rtl/hss_pkg.sv
// shared types, constants and helpers of the helmholtz stencil smoother
package hss_pkg;

   localparam int EDGE      = 8;
   localparam int FRAC_BITS = 16;
   localparam int SIDE      = EDGE + 2;
   localparam int PLANE     = SIDE * SIDE;
   localparam int WIN_DEPTH = 2 * PLANE + 1;
   localparam int MEM_AW    = $clog2(WIN_DEPTH);
   localparam int CW        = $clog2(SIDE);
   localparam int ACC_W     = 64 - FRAC_BITS + 3;
   localparam int NUM_TAPS  = 6;
   localparam int NUM_STEPS = 9;
   localparam logic signed [31:0] K_CONST = 32'(((8 << FRAC_BITS) + 5) / 10);

   // ages of the stored taps, read in this order
   localparam int TAP_CTR  = 0;  // center point, PLANE items back
   localparam int TAP_XM   = 1;
   localparam int TAP_XP   = 2;
   localparam int TAP_YM   = 3;
   localparam int TAP_YP   = 4;
   localparam int TAP_ZP   = 5;
   localparam logic [MEM_AW-1:0] TAP_AGE [NUM_TAPS] = '{
      MEM_AW'(PLANE), MEM_AW'(PLANE - 1), MEM_AW'(PLANE + 1),
      MEM_AW'(PLANE - SIDE), MEM_AW'(PLANE + SIDE), MEM_AW'(2 * PLANE)};

   // arithmetic steps of the shared multiplier
   localparam logic [3:0] STEP_FX_NEW = 4'd0;
   localparam logic [3:0] STEP_FX_OLD = 4'd1;
   localparam logic [3:0] STEP_FY_NEW = 4'd2;
   localparam logic [3:0] STEP_FY_OLD = 4'd3;
   localparam logic [3:0] STEP_FZ_NEW = 4'd4;
   localparam logic [3:0] STEP_FZ_OLD = 4'd5;
   localparam logic [3:0] STEP_KS     = 4'd6;
   localparam logic [3:0] STEP_ALPHA  = 4'd7;
   localparam logic [3:0] STEP_RELAX  = 4'd8;

   typedef struct packed {
      logic signed [31:0] rhs;
      logic signed [31:0] relax;
      logic signed [31:0] beta_z;
      logic signed [31:0] beta_y;
      logic signed [31:0] beta_x;
      logic signed [31:0] alpha;
      logic signed [31:0] phi;
   } point_type;

   typedef struct packed {
      logic       rd_en;
      logic [2:0] rd_sel;
      logic       cap_en;
      logic [2:0] cap_sel;
      logic       op_load;
      logic       mul_en;
      logic       consume;
      logic [3:0] step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic has_res;
      logic upd;
      logic out_free;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -64'sh8000_0000) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

FILE: rtl/hss_ctrl.sv
// sequencer of the smoother: tap reads, multiplier steps and result hand-off
module hss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  hss_pkg::status_type status,
   output logic                ready,
   output hss_pkg::cmd_type    cmd
);
   import hss_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_READ, S_MUL, S_OUT} state_type;

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [3:0] step_ff, step_in;
   logic [1:0] phase_ff, phase_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      phase_in = phase_ff;
      cmd      = '0;
      cmd.step = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && status.has_res) begin
               state_in = S_READ;
               cnt_in   = '0;
            end
         end
         S_READ: begin
            cmd.rd_en   = (cnt_ff < 3'(NUM_TAPS));
            cmd.rd_sel  = cnt_ff;
            cmd.cap_en  = (cnt_ff != 3'd0);
            cmd.cap_sel = cnt_ff - 3'd1;
            cnt_in      = cnt_ff + 3'd1;
            if (cnt_ff == 3'(NUM_TAPS)) begin
               state_in = status.upd ? S_MUL : S_OUT;
               step_in  = '0;
               phase_in = '0;
            end
         end
         S_MUL: begin
            cmd.op_load = (phase_ff == 2'd0);
            cmd.mul_en  = (phase_ff == 2'd1);
            cmd.consume = (phase_ff == 2'd2);
            phase_in    = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
            if (phase_ff == 2'd2) begin
               step_in = step_ff + 4'd1;
               if (step_ff == 4'(NUM_STEPS - 1)) begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         step_ff  <= '0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
         phase_ff <= phase_in;
      end
   end

`ifndef ASSERT_OFF
   a_mul_only_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> status.upd) else $error("multiply pass on pass-through point");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == S_IDLE)) else $error("item accepted while busy");
   a_read_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ && cnt_ff == 3'(NUM_TAPS)) |=> (state_ff != S_READ))
      else $error("read sequence overran");
`endif

endmodule

FILE: rtl/hss_datapath.sv
// window memory, position counters, shared multiplier and result register
module hss_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [223:0]        point,
   input  logic                parity_wr,
   input  logic                parity_data,
   input  hss_pkg::cmd_type    cmd,
   output hss_pkg::status_type status,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [31:0]         rsp_phi,
   output logic                rsp_last
);
   import hss_pkg::*;

   point_type mem [2**MEM_AW];
   point_type cur_ff, q_ff;
   point_type tap_ff [NUM_TAPS];

   logic [MEM_AW-1:0] wptr_ff, base_ff;
   logic [CW-1:0]     x_ff, y_ff, z_ff;
   logic              parity_ff, upd_ff, done_ff;
   logic              rsp_valid_ff, rsp_last_ff;
   logic [31:0]       rsp_phi_ff;

   logic signed [31:0]      opa_ff, opb_ff, opa_in, opb_in, r_ff, res_ff;
   logic signed [63:0]      prod_ff, prod_sh;
   logic signed [ACC_W-1:0] acc_ff, term;
   logic signed [63:0]      acc_ext, m_ff, h_v;
   logic signed [31:0]      h_sat;

   logic has_res_now, upd_now;
   localparam logic [CW-1:0] C_ONE  = CW'(1);
   localparam logic [CW-1:0] C_TWO  = CW'(2);
   localparam logic [CW-1:0] C_EDGE = CW'(EDGE);
   localparam logic [CW-1:0] C_LAST = CW'(SIDE - 1);

   // center of the stencil lies one plane behind the incoming point
   assign has_res_now = (z_ff >= C_TWO) && (x_ff >= C_ONE) && (x_ff <= C_EDGE)
                        && (y_ff >= C_ONE) && (y_ff <= C_EDGE);
   assign upd_now     = (x_ff[0] ^ y_ff[0] ^ z_ff[0]) == parity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff   <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         z_ff      <= '0;
         parity_ff <= 1'b0;
      end else begin
         if (parity_wr) begin
            parity_ff <= parity_data;
         end
         if (accept) begin
            wptr_ff <= wptr_ff + MEM_AW'(1);
            x_ff    <= (x_ff == C_LAST) ? '0 : x_ff + C_ONE;
            if (x_ff == C_LAST) begin
               y_ff <= (y_ff == C_LAST) ? '0 : y_ff + C_ONE;
               if (y_ff == C_LAST) begin
                  z_ff <= (z_ff == C_LAST) ? '0 : z_ff + C_ONE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem[wptr_ff] <= point;
         cur_ff       <= point;
         base_ff      <= wptr_ff;
         upd_ff       <= upd_now;
         done_ff      <= (x_ff == C_EDGE) && (y_ff == C_EDGE) && (z_ff == C_LAST);
      end
      if (cmd.rd_en) begin
         q_ff <= mem[base_ff - TAP_AGE[cmd.rd_sel]];
      end
      if (cmd.cap_en) begin
         tap_ff[cmd.cap_sel] <= q_ff;
      end
   end

   // operand selection per arithmetic step
   always_comb begin
      logic signed [31:0] pa, pb;
      pa     = '0;
      pb     = '0;
      opa_in = '0;
      case (cmd.step)
         STEP_FX_NEW: begin opa_in = tap_ff[TAP_XM].beta_x; pa = tap_ff[TAP_XM].phi;
            pb = tap_ff[TAP_CTR].phi; end
         STEP_FX_OLD: begin opa_in = tap_ff[TAP_CTR].beta_x; pa = tap_ff[TAP_CTR].phi;
            pb = tap_ff[TAP_XP].phi; end
         STEP_FY_NEW: begin opa_in = tap_ff[TAP_YM].beta_y; pa = tap_ff[TAP_YM].phi;
            pb = tap_ff[TAP_CTR].phi; end
         STEP_FY_OLD: begin opa_in = tap_ff[TAP_CTR].beta_y; pa = tap_ff[TAP_CTR].phi;
            pb = tap_ff[TAP_YP].phi; end
         STEP_FZ_NEW: begin opa_in = cur_ff.beta_z; pa = cur_ff.phi;
            pb = tap_ff[TAP_CTR].phi; end
         STEP_FZ_OLD: begin opa_in = tap_ff[TAP_CTR].beta_z; pa = tap_ff[TAP_CTR].phi;
            pb = tap_ff[TAP_ZP].phi; end
         default: ;
      endcase
      opb_in = sat32(64'(pa) - 64'(pb));
      case (cmd.step)
         STEP_KS:    begin opa_in = K_CONST; opb_in = sat32(acc_ext); end
         STEP_ALPHA: begin opa_in = tap_ff[TAP_CTR].alpha; opb_in = tap_ff[TAP_CTR].phi; end
         STEP_RELAX: begin opa_in = tap_ff[TAP_CTR].relax; opb_in = r_ff; end
         default: ;
      endcase
   end

   assign prod_sh = prod_ff >>> FRAC_BITS;
   assign term    = prod_sh[ACC_W-1:0];
   assign acc_ext = {{(64 - ACC_W){acc_ff[ACC_W-1]}}, acc_ff};
   assign h_v     = prod_sh - m_ff;
   assign h_sat   = sat32(h_v);

   always_ff @(posedge clock) begin
      if (accept) begin
         acc_ff <= '0;
      end
      if (cmd.op_load) begin
         opa_ff <= opa_in;
         opb_ff <= opb_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= opa_ff * opb_ff;
      end
      if (cmd.consume) begin
         case (cmd.step) inside
            STEP_FX_NEW, STEP_FY_NEW, STEP_FZ_NEW: acc_ff <= acc_ff + term;
            STEP_FX_OLD, STEP_FY_OLD, STEP_FZ_OLD: acc_ff <= acc_ff - term;
            STEP_KS:    m_ff   <= prod_sh;
            STEP_ALPHA: r_ff   <= sat32(64'(h_sat) - 64'(tap_ff[TAP_CTR].rhs));
            STEP_RELAX: res_ff <= sat32(64'(tap_ff[TAP_CTR].phi) - prod_sh);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_phi_ff  <= upd_ff ? res_ff : tap_ff[TAP_CTR].phi;
         rsp_last_ff <= done_ff;
      end
   end

   assign status.has_res  = has_res_now;
   assign status.upd      = upd_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_phi         = rsp_phi_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready)) else $error("result overwritten");
   a_wptr_step: assert property (@(posedge clock) disable iff (reset)
      accept |=> (wptr_ff == $past(wptr_ff) + MEM_AW'(1))) else $error("write pointer slip");
   a_relax_upd: assert property (@(posedge clock) disable iff (reset)
      (cmd.consume && cmd.step == STEP_RELAX) |-> upd_ff) else $error("update on wrong color");
`endif

endmodule

FILE: rtl/helmholtz_stencil_smoother.sv
// top level of the red-black helmholtz stencil smoother
// The brick, with its one-point halo, streams in raster order (x fastest, then y,
// then z), one point per req item; each interior point yields one rsp item one
// plane later, halo points yield none, and tlast marks the brick's last result.
// A halo or early point yields no result and keeps the block idle; a point whose
// center is interior but of the other color makes six reads of the window memory,
// one per cycle, through its single read port; an updated point also makes nine
// passes through the one shared 32x32 multiplier. New points wait for the idle state.
// The window memory needs no clearing: every tap read was written in the same brick.
module helmholtz_stencil_smoother (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // phi_in, alpha_in, beta_x_in, beta_y_in, beta_z_in, relax_in, rhs_in
   input  logic [223:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // phi_out
   output logic [31:0]  rsp_tdata,
   // brick_done
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   // update_parity
   input  logic         csr_data
);
   import hss_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       accept;

   // item accepted
   assign accept    = req_tvalid && req_tready;
   // register writes always taken
   assign csr_ready = 1'b1;

   hss_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .status (status),
      .ready  (req_tready),
      .cmd    (cmd)
   );

   hss_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .point       (req_tdata),
      .parity_wr   (csr_valid),
      .parity_data (csr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_phi     (rsp_tdata),
      .rsp_last    (rsp_tlast)
   );

endmodule
